// ----- hw/rtl/xrg_pkg.sv -----
package xrg_pkg;

  // Field and datapath widths.
  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = WordW / 2;
  localparam int unsigned BoundW  = 32;
  localparam int unsigned SpanW   = BoundW + 1;
  localparam int unsigned NumWords = 4;
  localparam int unsigned WordIdxW = $clog2(NumWords);

  // Seeding constants: xorshift64* shifts and multiplier halves.
  localparam logic [WordW-1:0] ZeroSeedSubst = 64'd4;
  localparam logic [HalfW-1:0] SeedMultLo    = 32'h4F6C_DD1D;
  localparam logic [HalfW-1:0] SeedMultHi    = 32'h2545_F491;
  localparam int unsigned      XsShiftA      = 12;
  localparam int unsigned      XsShiftB      = 25;
  localparam int unsigned      XsShiftC      = 27;

  // Generator constants.
  localparam int unsigned AdvShift   = 17;
  localparam int unsigned AdvRotW3   = 45;
  localparam int unsigned OutRot     = 7;

  // Divider: remainder bits retired per cycle and cycle count.
  localparam int unsigned DivBitsPerStep = 2;
  localparam int unsigned DivSteps       = WordW / DivBitsPerStep;
  localparam int unsigned DivCntW        = $clog2(DivSteps);

  typedef logic signed [BoundW-1:0] bound_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_SEED_LD,
    ST_XS,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_IDLE,
    ST_MIX,
    ST_DIV,
    ST_DONE
  } xrg_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                seed_ld;
    logic                xs;
    logic                m0;
    logic                m1;
    logic                m2;
    logic [WordIdxW-1:0] word_idx;
    logic                adv;
    logic                mix;
    logic                div_step;
    logic                load_out;
  } xrg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
  } xrg_status_t;

  // One xorshift64 round on the running seed word.
  function automatic logic [WordW-1:0] xs64(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    r = v ^ (v >> XsShiftA);
    r = r ^ (r << XsShiftB);
    r = r ^ (r >> XsShiftC);
    return r;
  endfunction

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] v,
                                              input int unsigned r);
    return (v << r) | (v >> (WordW - r));
  endfunction

  // One restoring division bit: shift in b, subtract span when it fits.
  function automatic logic [BoundW-1:0] div_bit(input logic [BoundW-1:0] rem,
                                                input logic b,
                                                input logic [SpanW-1:0] span);
    logic [SpanW-1:0] r;
    r = {rem, b};
    if (r >= span) begin
      r = r - span;
    end
    return r[BoundW-1:0];
  endfunction

endpackage

// ----- hw/rtl/xrg_req_if.sv -----
interface xrg_req_if import xrg_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  bound_t range_min;
  bound_t range_max;

  modport source (output valid, opcode, range_min, range_max, input ready);
  modport sink   (input valid, opcode, range_min, range_max, output ready);
endinterface

// ----- hw/rtl/xrg_rsp_if.sv -----
interface xrg_rsp_if import xrg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] raw_word;
  bound_t           bounded_value;
  logic             range_error;

  modport source (output valid, raw_word, bounded_value, range_error, input ready);
  modport sink   (input valid, raw_word, bounded_value, range_error, output ready);
endinterface

// ----- hw/rtl/xrg_ctrl.sv -----
module xrg_ctrl import xrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  xrg_status_t status_i,
  output xrg_cmd_t    cmd_o
);

  localparam logic [WordIdxW-1:0] RoundLast = WordIdxW'(NumWords - 1);
  localparam logic [DivCntW-1:0]  DivLast   = DivCntW'(DivSteps - 1);

  xrg_state_e          state_q, state_d;
  logic [WordIdxW-1:0] round_q, round_d;
  logic [DivCntW-1:0]  div_cnt_q, div_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state. A seed write restarts the seeding sequence.
  always_comb begin
    state_d = state_q;
    if (cfg_wr_i) begin
      state_d = ST_SEED_LD;
    end else begin
      unique case (state_q)
        ST_SEED_LD: state_d = ST_XS;
        ST_XS:      state_d = ST_M0;
        ST_M0:      state_d = ST_M1;
        ST_M1:      state_d = ST_M2;
        ST_M2:      state_d = (round_q == RoundLast) ? ST_IDLE : ST_XS;
        ST_IDLE:    state_d = accept ? ST_MIX : ST_IDLE;
        ST_MIX:     state_d = status_i.need_div ? ST_DIV : ST_DONE;
        ST_DIV:     state_d = (div_cnt_q == DivLast) ? ST_DONE : ST_DIV;
        ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
        default:    state_d = ST_SEED_LD;
      endcase
    end
  end

  // Seeding round and divider step counters.
  always_comb begin
    round_d   = round_q;
    div_cnt_d = div_cnt_q;
    if (state_q == ST_SEED_LD) begin
      round_d = '0;
    end else if (state_q == ST_M2) begin
      round_d = round_q + 1'b1;
    end
    if (state_q == ST_MIX) begin
      div_cnt_d = '0;
    end else if (state_q == ST_DIV) begin
      div_cnt_d = div_cnt_q + 1'b1;
    end
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.word_idx = round_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_SEED_LD: cmd_o.seed_ld = 1'b1;
      ST_XS:      cmd_o.xs      = 1'b1;
      ST_M0:      cmd_o.m0      = 1'b1;
      ST_M1:      cmd_o.m1      = 1'b1;
      ST_M2:      cmd_o.m2      = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.adv  = in_valid_i;
      end
      ST_MIX:     cmd_o.mix      = 1'b1;
      ST_DIV:     cmd_o.div_step = 1'b1;
      ST_DONE:    cmd_o.load_out = out_free;
      default:    cmd_o = '0;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED_LD;
      round_q     <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A finished result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // A seed write always restarts seeding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> state_q == ST_SEED_LD)
    else $error("seed write did not restart seeding");

  // Seeding ends after the last of the four rounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M2 && round_q == RoundLast && !cfg_wr_i) |=> state_q == ST_IDLE)
    else $error("seeding did not finish after four rounds");

  // Raw draws and range errors skip the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX && !status_i.need_div && !cfg_wr_i) |=> state_q == ST_DONE)
    else $error("divider entered without a valid span");

endmodule

// ----- hw/rtl/xrg_dp.sv -----
module xrg_dp import xrg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xrg_cmd_t         cmd_i,
  output xrg_status_t      status_o,
  input  logic             cfg_wr_i,
  input  logic [WordW-1:0] cfg_data_i,
  output logic [WordW-1:0] seed_o,
  input  logic             opcode_i,
  input  bound_t           range_min_i,
  input  bound_t           range_max_i,
  output logic [WordW-1:0] raw_word_o,
  output bound_t           bounded_value_o,
  output logic             range_error_o
);

  logic [WordW-1:0]  seed_q;
  logic [WordW-1:0]  sd_q;
  logic [WordW-1:0]  acc_q;
  logic [WordW-1:0]  w_q [NumWords];
  logic [WordW-1:0]  t5_q;
  logic [WordW-1:0]  word_q;
  logic [WordW-1:0]  divd_q;
  logic [BoundW-1:0] rem_q, rem_d;
  logic [SpanW-1:0]  span_q;
  logic              op_q;
  bound_t            lo_q, hi_q;
  logic [WordW-1:0]  res_raw_q;
  bound_t            res_bnd_q;
  logic              res_err_q;

  logic [HalfW-1:0]  mul_a, mul_b;
  logic [WordW-1:0]  prod;
  logic [SpanW-1:0]  diff;
  logic              inv_range;
  logic [WordW-1:0]  rot;
  logic [WordW-1:0]  w0n, w1n, w2n, w3n;

  // Seed register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_wr_i) begin
      seed_q <= cfg_data_i;
    end
  end

  assign seed_o = seed_q;

  // Shared 32x32 multiplier for the seed expansion partial products.
  assign mul_a = cmd_i.m2 ? sd_q[WordW-1:HalfW] : sd_q[HalfW-1:0];
  assign mul_b = cmd_i.m1 ? SeedMultHi : SeedMultLo;
  assign prod  = mul_a * mul_b;

  // Span check on the captured bounds, worked at 33 bits.
  assign diff      = {hi_q[BoundW-1], hi_q} - {lo_q[BoundW-1], lo_q};
  assign inv_range = diff[SpanW-1];
  assign status_o.need_div = op_q && !inv_range;

  // Generator advance, all terms from the current words.
  always_comb begin
    w2n = w_q[2] ^ w_q[0];
    w3n = w_q[3] ^ w_q[1];
    w1n = w_q[1] ^ w2n;
    w0n = w_q[0] ^ w3n;
    w2n = w2n ^ (w_q[1] << AdvShift);
    w3n = rotl64(w3n, AdvRotW3);
  end

  assign rot = rotl64(t5_q, OutRot);

  // Two restoring division bits per cycle.
  always_comb begin
    rem_d = rem_q;
    for (int unsigned i = 0; i < DivBitsPerStep; i++) begin
      rem_d = div_bit(rem_d, divd_q[WordW-1-i], span_q);
    end
  end

  // Seeding, generator words and draw datapath.
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_ld) begin
      sd_q <= (seed_q == '0) ? ZeroSeedSubst : seed_q;
    end
    if (cmd_i.xs) begin
      sd_q <= xs64(sd_q);
    end
    if (cmd_i.m0) begin
      acc_q <= prod;
    end
    if (cmd_i.m1) begin
      acc_q[WordW-1:HalfW] <= acc_q[WordW-1:HalfW] + prod[HalfW-1:0];
    end
    if (cmd_i.m2) begin
      w_q[cmd_i.word_idx] <= {acc_q[WordW-1:HalfW] + prod[HalfW-1:0],
                              acc_q[HalfW-1:0]};
    end
    if (cmd_i.adv) begin
      op_q   <= opcode_i;
      lo_q   <= range_min_i;
      hi_q   <= range_max_i;
      t5_q   <= w_q[1] + (w_q[1] << 2);
      w_q[0] <= w0n;
      w_q[1] <= w1n;
      w_q[2] <= w2n;
      w_q[3] <= w3n;
    end
    if (cmd_i.mix) begin
      word_q <= rot + (rot << 3);
      divd_q <= rot + (rot << 3);
      rem_q  <= '0;
      span_q <= diff + 1'b1;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      divd_q <= divd_q << DivBitsPerStep;
    end
    if (cmd_i.load_out) begin
      res_raw_q <= word_q;
      if (!op_q) begin
        res_bnd_q <= '0;
        res_err_q <= 1'b0;
      end else if (inv_range) begin
        res_bnd_q <= lo_q;
        res_err_q <= 1'b1;
      end else begin
        res_bnd_q <= lo_q + $signed(rem_q);
        res_err_q <= 1'b0;
      end
    end
  end

  assign raw_word_o      = res_raw_q;
  assign bounded_value_o = res_bnd_q;
  assign range_error_o   = res_err_q;

endmodule

// ----- hw/rtl/xoshiro256_range_generator.sv -----
// A raw draw or a range error goes through ST_MIX to ST_DONE; a bounded draw also runs
// ST_DIV, where the 64-by-33-bit remainder retires 2 bits per cycle. Requests are taken
// one at a time, the next only once ST_DONE has loaded the result, which waits for a free
// result register. Reset or a seed write runs a seeding pass (four rounds on one shared
// 32x32 multiplier); no request is taken until it ends. The seed resets to zero.
module xoshiro256_range_generator import xrg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [WordW-1:0] pwdata,
  output logic [WordW-1:0] prdata,
  output logic             pready,
  xrg_req_if.sink          req_i,
  xrg_rsp_if.source        rsp_o
);

  xrg_cmd_t         cmd;
  xrg_status_t      status;
  logic             cfg_wr;
  logic [WordW-1:0] seed;

  // Register decode: the seed register answers at any address with bit 3 clear, zero included.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[3];
  assign prdata = paddr[3] ? '0 : seed;

  xrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xrg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_wr_i        (cfg_wr),
    .cfg_data_i      (pwdata),
    .seed_o          (seed),
    .opcode_i        (req_i.opcode),
    .range_min_i     (req_i.range_min),
    .range_max_i     (req_i.range_max),
    .raw_word_o      (rsp_o.raw_word),
    .bounded_value_o (rsp_o.bounded_value),
    .range_error_o   (rsp_o.range_error)
  );

endmodule

// ----- dv/xoshiro256_range_generator_tb.sv -----
`timescale 1ns / 100ps

module xoshiro256_range_generator_tb;
  import xrg_pkg::*;

  // Register map: the seed is the only register and it is 64 bits wide.
  localparam logic [3:0]       SeedAddr    = 4'h0;
  localparam logic [WordW-1:0] SeedMult    = 64'h2545_F491_4F6C_DD1D;
  localparam logic [WordW-1:0] ZeroSeed    = 64'd4;
  localparam bound_t           BoundMin    = 32'sh8000_0000;
  localparam bound_t           BoundMax    = 32'sh7FFF_FFFF;
  localparam int unsigned      DrainCycles = 40;
  localparam int unsigned      PhaseDraws  = 300;

  typedef enum logic {
    OP_RAW     = 1'b0,
    OP_BOUNDED = 1'b1
  } op_e;

  typedef struct {
    op_e    op;
    bound_t lo;
    bound_t hi;
  } draw_req_t;

  typedef struct {
    logic [WordW-1:0] raw;
    bound_t           bounded;
    logic             err;
  } draw_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [3:0]       paddr;
  logic [WordW-1:0] pwdata;
  logic [WordW-1:0] prdata;
  logic             pready;

  xrg_req_if req_if ();
  xrg_rsp_if rsp_if ();

  xoshiro256_range_generator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  // Predicted generator state and the draws still owed by the block.
  logic [WordW-1:0] gen_words [NumWords];
  draw_t            draw_q [$];
  int               errors  = 0;
  bit               no_idle = 1'b0;
  int               ready_hold = 0;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Give up if the run hangs.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [WordW-1:0] rol64(input logic [WordW-1:0] v,
                                             input int unsigned r);
    return (v << r) | (v >> (WordW - r));
  endfunction

  // Seed expansion: xorshift64* rounds, each scaled by the multiplier.
  function automatic void expand_seed(input logic [WordW-1:0] sd);
    logic [WordW-1:0] s;
    s = (sd == '0) ? ZeroSeed : sd;
    for (int i = 0; i < NumWords; i++) begin
      s = s ^ (s >> 12);
      s = s ^ (s << 25);
      s = s ^ (s >> 27);
      gen_words[i] = s * SeedMult;
    end
  endfunction

  // One xoshiro256** step plus the bounded mapping of its output word.
  function automatic draw_t predict_draw(input draw_req_t r);
    logic [WordW-1:0] word;
    logic [WordW-1:0] t;
    logic [WordW-1:0] span;
    logic [WordW-1:0] rem;
    longint           lo;
    longint           hi;
    draw_t            d;
    word = rol64(gen_words[1] * 64'd5, 7) * 64'd9;
    t = gen_words[1] << 17;
    gen_words[2] = gen_words[2] ^ gen_words[0];
    gen_words[3] = gen_words[3] ^ gen_words[1];
    gen_words[1] = gen_words[1] ^ gen_words[2];
    gen_words[0] = gen_words[0] ^ gen_words[3];
    gen_words[2] = gen_words[2] ^ t;
    gen_words[3] = rol64(gen_words[3], 45);
    d.raw = word;
    d.bounded = '0;
    d.err = 1'b0;
    if (r.op == OP_BOUNDED) begin
      lo = r.lo;
      hi = r.hi;
      if (hi < lo) begin
        d.err = 1'b1;
        d.bounded = r.lo;
      end else begin
        span = 64'(hi - lo + 1);
        rem = word % span;
        d.bounded = bound_t'(lo + longint'(rem));
      end
    end
    return d;
  endfunction

  function automatic draw_req_t mk_req(input op_e op, input bound_t lo, input bound_t hi);
    draw_req_t r;
    r.op = op;
    r.lo = lo;
    r.hi = hi;
    return r;
  endfunction

  // Random request, weighted toward bounded draws with varied span shapes.
  function automatic draw_req_t random_req();
    draw_req_t   r;
    longint      top;
    int unsigned sel;
    r.op = ($urandom_range(0, 3) == 0) ? OP_RAW : OP_BOUNDED;
    r.lo = bound_t'($urandom);
    r.hi = bound_t'($urandom);
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: top = longint'(r.lo) + longint'($urandom_range(0, 15));
      3: begin
        r.lo = BoundMin;
        top = BoundMax;
      end
      4: top = r.lo;
      5: top = longint'(r.lo) + (longint'(1) << $urandom_range(0, 31)) - 1;
      6: top = longint'(r.lo) - longint'($urandom_range(1, 1000));
      default: top = r.hi;
    endcase
    if (top > BoundMax) begin
      top = BoundMax;
    end
    if (top < BoundMin) begin
      top = BoundMin;
    end
    r.hi = bound_t'(top);
    return r;
  endfunction

  // Drive one request, with an optional gap in front, and record its result.
  task automatic send_draw(input draw_req_t r);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
      end
    end
    @(negedge clk_i);
    req_if.valid     = 1'b1;
    req_if.opcode    = r.op;
    req_if.range_min = r.lo;
    req_if.range_max = r.hi;
    do @(posedge clk_i); while (!req_if.ready);
    draw_q.push_back(predict_draw(r));
  endtask

  task automatic wait_drained();
    while (draw_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Seed write over the configuration port, only once the block is idle.
  task automatic write_seed(input logic [WordW-1:0] sd);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait_drained();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SeedAddr;
    pwdata  = sd;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    expand_seed(sd);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Response side: ready drops in bursts of random length, except in the no-gap phase.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      rsp_if.ready = 1'b0;
      ready_hold--;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      rsp_if.ready = 1'b0;
      ready_hold = $urandom_range(0, 3);
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (draw_q.size() == 0) begin
        $display("%0t: result with none expected: raw_word %h", $time, rsp_if.raw_word);
        errors++;
      end else begin
        want = draw_q.pop_front();
        if (rsp_if.raw_word !== want.raw) begin
          $display("%0t: raw_word mismatch: expected %h, actual %h",
                   $time, want.raw, rsp_if.raw_word);
          errors++;
        end
        if (rsp_if.bounded_value !== want.bounded) begin
          $display("%0t: bounded_value mismatch: expected %0d, actual %0d",
                   $time, want.bounded, rsp_if.bounded_value);
          errors++;
        end
        if (rsp_if.range_error !== want.err) begin
          $display("%0t: range_error mismatch: expected %b, actual %b",
                   $time, want.err, rsp_if.range_error);
          errors++;
        end
      end
    end
  end

  // Draws straight after reset, so the zero seed, replaced by four, is used.
  task automatic test_reset_seed();
    send_draw(mk_req(OP_RAW, 32'sd0, 32'sd0));
    send_draw(mk_req(OP_BOUNDED, 32'sd0, 32'sd9));
    send_draw(mk_req(OP_RAW, BoundMax, BoundMin));
  endtask

  // Field extremes, both operations, full and inverted ranges.
  task automatic test_directed_ranges();
    send_draw(mk_req(OP_RAW, BoundMin, BoundMax));
    send_draw(mk_req(OP_RAW, -32'sd1, -32'sd1));
    send_draw(mk_req(OP_BOUNDED, BoundMin, BoundMax));
    send_draw(mk_req(OP_BOUNDED, 32'sd0, 32'sd0));
    send_draw(mk_req(OP_BOUNDED, BoundMin, BoundMin));
    send_draw(mk_req(OP_BOUNDED, BoundMax, BoundMax));
    send_draw(mk_req(OP_BOUNDED, 32'sd0, 32'sd1));
    send_draw(mk_req(OP_BOUNDED, -32'sd1, 32'sd0));
    send_draw(mk_req(OP_BOUNDED, BoundMax, BoundMin));
    send_draw(mk_req(OP_BOUNDED, 32'sd1, 32'sd0));
    send_draw(mk_req(OP_BOUNDED, 32'sd5, 32'sd4));
    send_draw(mk_req(OP_BOUNDED, BoundMin, -32'sd1));
    send_draw(mk_req(OP_BOUNDED, 32'sd0, BoundMax));
    send_draw(mk_req(OP_BOUNDED, -32'sd1, BoundMax));
    send_draw(mk_req(OP_BOUNDED, BoundMin, 32'sd0));
    send_draw(mk_req(OP_BOUNDED, BoundMin + 32'sd1, BoundMax));
    send_draw(mk_req(OP_BOUNDED, BoundMin, BoundMax - 32'sd1));
    send_draw(mk_req(OP_BOUNDED, -32'sd10, 32'sd10));
    send_draw(mk_req(OP_BOUNDED, 32'sd100, 32'sd1000));
    send_draw(mk_req(OP_BOUNDED, 32'sd0, 32'sd2));
    send_draw(mk_req(OP_BOUNDED, 32'sd0, 32'sd3));
  endtask

  // Reseeding with zero, all ones and a few other values.
  task automatic test_seed_values();
    logic [WordW-1:0] seeds [6];
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = 64'd1;
    seeds[3] = ZeroSeed;
    seeds[4] = 64'h8000_0000_0000_0000;
    seeds[5] = {$urandom, $urandom};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      repeat (6) begin
        send_draw(random_req());
      end
    end
  endtask

  // Long random traffic under several random seeds; the last phase runs without gaps.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      write_seed({$urandom, $urandom});
      if (phase == 4) begin
        no_idle = 1'b1;
      end
      repeat (PhaseDraws) begin
        send_draw(random_req());
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.opcode    = OP_RAW;
    req_if.range_min = '0;
    req_if.range_max = '0;
    rsp_if.ready     = 1'b0;
    expand_seed('0);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_seed();
    test_directed_ranges();
    test_seed_values();
    test_random_traffic();

    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/xrg_pkg.sv
hw/rtl/xrg_req_if.sv
hw/rtl/xrg_rsp_if.sv
hw/rtl/xrg_ctrl.sv
hw/rtl/xrg_dp.sv
hw/rtl/xoshiro256_range_generator.sv
dv/xoshiro256_range_generator_tb.sv
